// ===== hdl/tcw_pkg.sv =====
// Package for the text console character writer.
// Word types, character codes, register indexes and cursor action flags.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

   // Field widths fixed by the interface
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int CURSOR_W = 11;
   localparam int ADDR_W   = 11;
   localparam int COLOR_W  = 4;
   localparam int CELL_W   = CHAR_W + ATTR_W;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = COLOR_W;
   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR = 1'd1;

   // Item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // Control characters
   localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
   localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
   localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
   localparam logic [CHAR_W-1:0] CH_HT  = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
   localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
   localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_ESC = 8'h1B;

   // Rows moved by a vertical tab
   localparam int VT_ROWS = 6;

   typedef struct packed {
      logic                kind;
      logic [CHAR_W-1:0]   char_code;
      logic [ADDR_W-1:0]   read_address;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]   cell_char;
      logic [ATTR_W-1:0]   cell_attr;
      logic [CURSOR_W-1:0] cursor;
   } rsp_type;

   // Memory action decoded from a write word
   typedef struct packed {
      logic store;   // write char at the cursor
      logic blank;   // zero the cell before the cursor
      logic clear;   // wipe the whole screen
   } act_type;

endpackage

// ===== hdl/text_console_char_writer.sv =====
// Text console character writer: screen memory, cursor unit and item sequencer.
// Results are registered: an accepted word moves the sequencer to its response
// state, which loads the output register when it is free; a form feed first
// clears all COLUMNS*ROWS cells. A new word is accepted only after that load.
// Reset: synchronous; afterwards a clearing pass over all COLUMNS*ROWS cells
// zeroes the screen while no word is accepted (register writes still taken).
`timescale 1ns / 1ps

module text_console_char_writer #(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STEP = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tcw_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tcw_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int CW    = $clog2(CELLS);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RESP  = 2'd1;
   localparam logic [1:0] ST_CLEAR = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] clr_cnt_ff, clr_cnt_in;
   logic          clr_resp_ff, clr_resp_in;
   logic          pend_read_ff, pend_read_in;
   logic          rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [tcw_pkg::COLOR_W-1:0] fg_ff, bg_ff;

   logic accept, accept_wr, accept_rd, out_free, in_range;
   tcw_pkg::act_type act;
   logic [CW-1:0] cursor, prev;
   logic [CW+tcw_pkg::ADDR_W-1:0]   addr_wide;
   logic [CW+tcw_pkg::CURSOR_W-1:0] cursor_wide;

   logic                       wr_en;
   logic [CW-1:0]              wr_addr;
   logic [tcw_pkg::CELL_W-1:0] wr_data;
   logic [tcw_pkg::CELL_W-1:0] rd_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign accept_wr = accept && (req_data.kind == tcw_pkg::KIND_WRITE);
   assign accept_rd = accept && (req_data.kind == tcw_pkg::KIND_READ);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign in_range  = 32'(req_data.read_address) < 32'(CELLS);
   assign addr_wide = {{CW{1'b0}}, req_data.read_address};

   // Color registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= '0;
         bg_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == tcw_pkg::CSR_FG_COLOR) begin
            fg_ff <= csr_wdata;
         end
         if (csr_index == tcw_pkg::CSR_BG_COLOR) begin
            bg_ff <= csr_wdata;
         end
      end
   end

   tcw_cursor_unit #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STEP (TAB_STEP)
   ) u_cursor (
      .clock    (clock),
      .reset    (reset),
      .step_i   (accept_wr),
      .code_i   (req_data.char_code),
      .act_o    (act),
      .cursor_o (cursor),
      .prev_o   (prev)
   );

   // Memory write select: clearing pass, stored char or backspace blank
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cursor;
      wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
      end else if (accept_wr && act.store) begin
         wr_en   = 1'b1;
         wr_data = {bg_ff, fg_ff, req_data.char_code};
      end else if (accept_wr && act.blank) begin
         wr_en   = 1'b1;
         wr_addr = prev;
      end
   end

   tcw_screen_ram #(
      .DEPTH (CELLS),
      .AW    (CW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept_rd && in_range),
      .rd_addr (addr_wide[CW-1:0]),
      .rd_data (rd_data)
   );

   assign cursor_wide = {{tcw_pkg::CURSOR_W{1'b0}}, cursor};

   // Sequencer and output register
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_resp_in  = clr_resp_ff;
      pend_read_in = pend_read_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_read_in = accept_rd && in_range;
               if (accept_wr && act.clear) begin
                  state_in    = ST_CLEAR;
                  clr_cnt_in  = '0;
                  clr_resp_in = 1'b1;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.cell_char = pend_read_ff ? rd_data[tcw_pkg::CHAR_W-1:0] : '0;
               rsp_data_in.cell_attr = pend_read_ff ? rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W]
                                                    : '0;
               rsp_data_in.cursor    = cursor_wide[tcw_pkg::CURSOR_W-1:0];
               state_in              = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CW'(CELLS - 1)) begin
               state_in = clr_resp_ff ? ST_RESP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         clr_resp_ff  <= 1'b0;
         pend_read_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_resp_ff  <= clr_resp_in;
         pend_read_ff <= pend_read_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/tcw_screen_ram.sv =====
// Screen cell memory: one write port, one registered read port.
// Depends on tcw_pkg for the cell width.
`timescale 1ns / 1ps

module tcw_screen_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [tcw_pkg::CELL_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [tcw_pkg::CELL_W-1:0] rd_data
);

   logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
   logic [tcw_pkg::CELL_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tcw_cursor_unit.sv =====
// Cursor tracking: row base, column, cursor index and escape flag.
// Decodes a character word into cursor movement and a memory action.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_cursor_unit #(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STEP = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_i,
   input  logic [tcw_pkg::CHAR_W-1:0]    code_i,
   output tcw_pkg::act_type              act_o,
   output logic [$clog2(COLUMNS*ROWS)-1:0] cursor_o,
   output logic [$clog2(COLUMNS*ROWS)-1:0] prev_o
);

   localparam int CELLS    = COLUMNS * ROWS;
   localparam int CW       = $clog2(CELLS);
   localparam int COLW     = $clog2(COLUMNS);
   localparam int LAST_ROW = CELLS - COLUMNS;
   localparam int VT_ADD   = (tcw_pkg::VT_ROWS % ROWS) * COLUMNS;

   logic [COLW-1:0] col_ff, col_in;
   logic [CW-1:0]   rbase_ff, rbase_in;
   logic [CW-1:0]   cursor_ff, cursor_in;
   logic            esc_ff, esc_in;

   logic [CW-1:0]   row_next, row_prev, row_vt;
   logic [CW:0]     vt_sum, vt_wrap;
   logic [COLW:0]   tab_sum, tab_wrap;

   // Neighbor rows, wrapping over the screen
   assign row_next = (rbase_ff == CW'(LAST_ROW)) ? '0 : rbase_ff + CW'(COLUMNS);
   assign row_prev = (rbase_ff == '0) ? CW'(LAST_ROW) : rbase_ff - CW'(COLUMNS);
   assign vt_sum   = {1'b0, rbase_ff} + (CW+1)'(VT_ADD);
   assign vt_wrap  = vt_sum - (CW+1)'(CELLS);
   assign row_vt   = (vt_sum >= (CW+1)'(CELLS)) ? vt_wrap[CW-1:0] : vt_sum[CW-1:0];
   assign tab_sum  = {1'b0, col_ff} + (COLW+1)'(TAB_STEP);
   assign tab_wrap = tab_sum - (COLW+1)'(COLUMNS);

   // Character decode
   always_comb begin
      col_in   = col_ff;
      rbase_in = rbase_ff;
      esc_in   = esc_ff;
      act_o    = '0;
      case (code_i)
         tcw_pkg::CH_NUL, tcw_pkg::CH_BEL: begin
         end
         tcw_pkg::CH_BS: begin
            act_o.blank = 1'b1;
            if (col_ff == '0) begin
               col_in   = COLW'(COLUMNS - 1);
               rbase_in = row_prev;
            end else begin
               col_in = col_ff - 1'b1;
            end
         end
         tcw_pkg::CH_HT: begin
            if (tab_sum >= (COLW+1)'(COLUMNS)) begin
               col_in   = tab_wrap[COLW-1:0];
               rbase_in = row_next;
            end else begin
               col_in = tab_sum[COLW-1:0];
            end
         end
         tcw_pkg::CH_LF: begin
            col_in   = '0;
            rbase_in = row_next;
         end
         tcw_pkg::CH_VT: begin
            rbase_in = row_vt;
         end
         tcw_pkg::CH_FF: begin
            act_o.clear = 1'b1;
         end
         tcw_pkg::CH_CR: begin
            col_in = '0;
         end
         tcw_pkg::CH_ESC: begin
            esc_in = 1'b1;
         end
         default: begin
            if (esc_ff) begin
               // swallowed by a pending escape
               esc_in = 1'b0;
            end else begin
               act_o.store = 1'b1;
               if (col_ff == COLW'(COLUMNS - 1)) begin
                  col_in   = '0;
                  rbase_in = row_next;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
      endcase
   end

   assign cursor_in = rbase_in + CW'(col_in);

   // Cursor registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         rbase_ff  <= '0;
         cursor_ff <= '0;
         esc_ff    <= 1'b0;
      end else if (step_i) begin
         col_ff    <= col_in;
         rbase_ff  <= rbase_in;
         cursor_ff <= cursor_in;
         esc_ff    <= esc_in;
      end
   end

   assign cursor_o = cursor_ff;
   assign prev_o   = (cursor_ff == '0) ? CW'(CELLS - 1) : cursor_ff - 1'b1;

endmodule

// ===== hdl/tcw_checker.sv =====
// Port-level checks for the text console character writer, bound to the top.
// Depends on tcw_pkg and text_console_char_writer.
`timescale 1ns / 1ps

module tcw_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tcw_pkg::rsp_type rsp_data
);

   localparam int CELLS = COLUMNS * ROWS;

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // One word at a time: no accept right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after an accepted word");

   // Screen is being cleared right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("input ready during the reset clearing pass");

   // Cursor stays on the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.cursor) < 32'(CELLS)) || (CELLS > 2048))
      else $error("cursor beyond the screen");

endmodule

bind text_console_char_writer tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (.*);

// ===== tb/testbench.sv =====
// Testbench for text_console_char_writer: directed and random character and read words,
// checked against a shadow screen, cursor and escape flag kept in the bench.
// Depends on tcw_pkg and the text_console_char_writer RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int TAB_STEP    = 8;
   localparam int SCREEN_SIZE = COLUMNS * ROWS;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_REPORTS = 10;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   tcw_pkg::req_type               req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   tcw_pkg::rsp_type               rsp_data;
   logic                           csr_we = 1'b0;
   logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index = tcw_pkg::CSR_FG_COLOR;
   logic [tcw_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow of the block's state
   logic [tcw_pkg::CHAR_W-1:0]  shadow_char [SCREEN_SIZE];
   logic [tcw_pkg::ATTR_W-1:0]  shadow_attr [SCREEN_SIZE];
   int                          cur_pos;
   bit                          esc_armed;
   logic [tcw_pkg::COLOR_W-1:0] fg_nib;
   logic [tcw_pkg::COLOR_W-1:0] bg_nib;

   tcw_pkg::rsp_type expected_cells[$];
   tcw_pkg::req_type held_word;
   bit      word_held = 1'b0;
   bit      idle_on = 1'b1;
   bit      long_hold_req = 1'b0;
   int      mismatches = 0;
   int      words_done = 0;
   int      reads_done = 0;
   int      clears_done = 0;
   int      color_settings = 0;

   logic [tcw_pkg::CHAR_W-1:0] ctl_codes [8] = '{tcw_pkg::CH_NUL, tcw_pkg::CH_BEL,
                                                 tcw_pkg::CH_BS, tcw_pkg::CH_HT,
                                                 tcw_pkg::CH_LF, tcw_pkg::CH_VT,
                                                 tcw_pkg::CH_CR, tcw_pkg::CH_ESC};

   text_console_char_writer #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STEP (TAB_STEP)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Update the shadow screen for one accepted word and queue its expected result
   function automatic void console_update(input tcw_pkg::req_type w);
      tcw_pkg::rsp_type r;
      int               col;
      r = '0;
      words_done++;
      if (w.kind == tcw_pkg::KIND_WRITE) begin
         col = cur_pos % COLUMNS;
         case (w.char_code)
            tcw_pkg::CH_NUL, tcw_pkg::CH_BEL: begin
            end
            tcw_pkg::CH_BS: begin
               cur_pos = (cur_pos + SCREEN_SIZE - 1) % SCREEN_SIZE;
               shadow_char[cur_pos] = '0;
               shadow_attr[cur_pos] = '0;
            end
            tcw_pkg::CH_HT: cur_pos = (cur_pos + TAB_STEP) % SCREEN_SIZE;
            tcw_pkg::CH_LF: cur_pos = (cur_pos + COLUMNS - col) % SCREEN_SIZE;
            tcw_pkg::CH_VT: cur_pos = (cur_pos + tcw_pkg::VT_ROWS * COLUMNS) % SCREEN_SIZE;
            tcw_pkg::CH_FF: begin
               clears_done++;
               for (int i = 0; i < SCREEN_SIZE; i++) begin
                  shadow_char[i] = '0;
                  shadow_attr[i] = '0;
               end
            end
            tcw_pkg::CH_CR: cur_pos = cur_pos - col;
            tcw_pkg::CH_ESC: esc_armed = 1'b1;
            default: begin
               if (esc_armed) begin
                  // escape eats this character
                  esc_armed = 1'b0;
               end else begin
                  shadow_char[cur_pos] = w.char_code;
                  shadow_attr[cur_pos] = {bg_nib, fg_nib};
                  cur_pos = (cur_pos + 1) % SCREEN_SIZE;
               end
            end
         endcase
      end else begin
         reads_done++;
         if (w.read_address < SCREEN_SIZE) begin
            r.cell_char = shadow_char[w.read_address];
            r.cell_attr = shadow_attr[w.read_address];
         end
      end
      r.cursor = tcw_pkg::CURSOR_W'(cur_pos);
      expected_cells.push_back(r);
   endfunction

   function automatic tcw_pkg::req_type char_word(input logic [tcw_pkg::CHAR_W-1:0] c);
      tcw_pkg::req_type w;
      w.kind         = tcw_pkg::KIND_WRITE;
      w.char_code    = c;
      w.read_address = tcw_pkg::ADDR_W'($urandom_range(0, 2047));
      return w;
   endfunction

   function automatic tcw_pkg::req_type read_word(input int addr);
      tcw_pkg::req_type w;
      w.kind         = tcw_pkg::KIND_READ;
      w.char_code    = tcw_pkg::CHAR_W'($urandom_range(0, 255));
      w.read_address = tcw_pkg::ADDR_W'(addr);
      return w;
   endfunction

   // Mostly text runs with a sprinkle of controls, escapes and reads
   function automatic tcw_pkg::req_type random_word();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
         return read_word((cur_pos + SCREEN_SIZE - $urandom_range(0, 12)) % SCREEN_SIZE);
      end else if (pick < 28) begin
         return read_word($urandom_range(0, SCREEN_SIZE - 1));
      end else if (pick < 30) begin
         return read_word($urandom_range(SCREEN_SIZE, 2047));
      end else if (pick < 40) begin
         return char_word(ctl_codes[$urandom_range(0, 7)]);
      end else if (pick < 46) begin
         if ($urandom_range(0, 24) == 0) return char_word(tcw_pkg::CH_FF);
         return char_word(tcw_pkg::CHAR_W'($urandom_range(0, 255)));
      end
      return char_word(tcw_pkg::CHAR_W'($urandom_range(8'h20, 8'h7E)));
   endfunction

   // Wait for the held word to be taken, then account for it
   task automatic finish_word();
      if (word_held) begin
         do @(posedge clock); while (!req_ready);
         console_update(held_word);
         word_held = 1'b0;
      end
   endtask

   // Offer one word; it stays on the bus until the next call or end_words
   task automatic send_word(input tcw_pkg::req_type w);
      bit prior;
      prior = word_held;
      finish_word();
      if (idle_on && $urandom_range(0, 4) == 0) begin
         if (prior) req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      held_word = w;
      word_held = 1'b1;
   endtask

   task automatic end_words();
      if (word_held) begin
         finish_word();
         req_valid <= 1'b0;
      end
   endtask

   task automatic drain_results();
      end_words();
      while (expected_cells.size() != 0) @(posedge clock);
   endtask

   // Register writes, made only with no word in flight (the block idle or clearing the screen)
   task automatic set_colors(input logic [tcw_pkg::COLOR_W-1:0] fg,
                             input logic [tcw_pkg::COLOR_W-1:0] bg);
      csr_we    <= 1'b1;
      csr_index <= tcw_pkg::CSR_FG_COLOR;
      csr_wdata <= fg;
      @(posedge clock);
      csr_index <= tcw_pkg::CSR_BG_COLOR;
      csr_wdata <= bg;
      @(posedge clock);
      csr_we <= 1'b0;
      fg_nib = fg;
      bg_nib = bg;
      color_settings++;
   endtask

   // Every control code, wraps at both screen ends, escape corners, edge reads
   task automatic test_directed();
      send_word(char_word(tcw_pkg::CH_BS));   // cursor 0 steps back to the last cell
      send_word(char_word(8'h41));            // stored in the last cell, cursor wraps
      send_word(read_word(SCREEN_SIZE - 1));
      send_word(char_word(tcw_pkg::CH_BS));
      send_word(read_word(SCREEN_SIZE - 1));
      send_word(char_word(tcw_pkg::CH_LF));   // newline from the last row
      send_word(char_word(8'hFF));
      send_word(char_word(8'h80));
      send_word(char_word(8'h01));            // unassigned control gets stored
      send_word(char_word(tcw_pkg::CH_NUL));
      send_word(char_word(tcw_pkg::CH_BEL));
      send_word(char_word(tcw_pkg::CH_HT));
      send_word(char_word(tcw_pkg::CH_CR));
      send_word(char_word(tcw_pkg::CH_VT));
      send_word(char_word(tcw_pkg::CH_ESC));
      send_word(char_word(tcw_pkg::CH_ESC));  // second escape keeps it armed
      send_word(char_word(8'h78));            // swallowed
      send_word(char_word(8'h20));
      send_word(char_word(tcw_pkg::CH_ESC));
      send_word(char_word(tcw_pkg::CH_BS));   // backspace leaves escape armed
      send_word(char_word(8'h7E));            // swallowed
      send_word(read_word(0));
      send_word(read_word(SCREEN_SIZE));
      send_word(read_word(2047));
      send_word(char_word(tcw_pkg::CH_FF));
      send_word(read_word(tcw_pkg::VT_ROWS * COLUMNS));
      drain_results();
   endtask

   task automatic test_random_text(input int count);
      for (int i = 0; i < count; i++) send_word(random_word());
      drain_results();
   endtask

   // Receiver stalls for a long stretch while words keep coming
   task automatic test_backpressure();
      long_hold_req = 1'b1;
      for (int i = 0; i < 30; i++) send_word(random_word());
      end_words();
      while (long_hold_req) @(posedge clock);
      drain_results();
   endtask

   // Sender goes quiet until every result is back, then resumes
   task automatic test_sender_pause();
      for (int i = 0; i < 20; i++) send_word(random_word());
      drain_results();
      for (int i = 0; i < 20; i++) send_word(random_word());
      drain_results();
   endtask

   task automatic test_steady_stream();
      idle_on = 1'b0;
      test_random_text(60);
   endtask

   // Receiver side: random stall bursts, plus the long hold when asked
   initial begin : rsp_side
      int n;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_ready <= 1'b0;
            for (n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
            rsp_ready <= 1'b1;
            long_hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic void report_mismatch(input string what, input tcw_pkg::rsp_type want,
                                           input tcw_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s: expected char %h attr %h cursor %0d, got char %h attr %h cursor %0d",
                  $realtime, what, want.cell_char, want.cell_attr, want.cursor,
                  got.cell_char, got.cell_attr, got.cursor);
   endfunction

   // Result check against the oldest expectation
   always @(posedge clock) begin : rsp_check
      tcw_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cells.size() == 0) begin
            report_mismatch("unexpected word", '0, rsp_data);
         end else begin
            want = expected_cells.pop_front();
            if (rsp_data.cell_char !== want.cell_char ||
                rsp_data.cell_attr !== want.cell_attr ||
                rsp_data.cursor    !== want.cursor)
               report_mismatch("result mismatch", want, rsp_data);
         end
      end
   end

   initial begin : main
      int wait_cycles;
      cur_pos   = 0;
      esc_armed = 1'b0;
      fg_nib    = '0;
      bg_nib    = '0;
      for (int i = 0; i < SCREEN_SIZE; i++) begin
         shadow_char[i] = '0;
         shadow_attr[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      set_colors(4'hF, 4'h0);
      test_directed();
      set_colors(4'h0, 4'hF);
      test_random_text(100);
      set_colors(4'hF, 4'hF);
      test_backpressure();
      set_colors(tcw_pkg::COLOR_W'($urandom_range(0, 15)),
                 tcw_pkg::COLOR_W'($urandom_range(0, 15)));
      test_random_text(100);
      set_colors(4'h0, 4'h0);
      test_sender_pause();
      set_colors(tcw_pkg::COLOR_W'($urandom_range(0, 15)),
                 tcw_pkg::COLOR_W'($urandom_range(0, 15)));
      test_random_text(100);
      test_steady_stream();

      // Let any stray result show up, then settle
      end_words();
      wait_cycles = 0;
      while (expected_cells.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (expected_cells.size() != 0) begin
         $display("%0d expected results never arrived", expected_cells.size());
         mismatches += expected_cells.size();
      end

      $display("Covered %0d words: %0d cell reads, %0d screen clears, %0d color settings",
               words_done, reads_done, clears_done, color_settings);
      $display("Includes a %0d-cycle receiver hold and a full sender pause", HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #4000000;
      $display("Timeout with %0d results outstanding", expected_cells.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
